// ----- hdl/vca_pkg.sv -----
// Shared constants, command and status codes for the voice channel allocator.
// No dependencies.
package vca_pkg;

	// Channel table size (2 to 16)
	localparam int CHANNELS = 8;
	localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	localparam int HANDLE_W = 4;
	localparam int ADDR_W   = 32;
	localparam int BYTES_W  = 24;
	localparam int SAMP_W   = 22;
	localparam int COUNT_W  = 5;
	localparam int STATUS_W = 2;
	localparam int CMD_W    = 3;

	// Input tdata layout, low bit up
	localparam int IN_HANDLE_LO = 0;
	localparam int IN_ADDR_LO   = IN_HANDLE_LO + HANDLE_W;
	localparam int IN_BYTES_LO  = IN_ADDR_LO + ADDR_W;
	localparam int IN_PLAY_BIT  = IN_BYTES_LO + BYTES_W;
	localparam int IN_LOOP_BIT  = IN_PLAY_BIT + 1;
	localparam int IN_BITS      = IN_LOOP_BIT + 1;
	localparam int S_TDATA_W    = ((IN_BITS + 7) / 8) * 8;

	// Output tdata layout, low bit up
	localparam int OUT_HANDLE_LO = 0;
	localparam int OUT_STATUS_LO = OUT_HANDLE_LO + HANDLE_W;
	localparam int OUT_COUNT_LO  = OUT_STATUS_LO + STATUS_W;
	localparam int OUT_BITS      = OUT_COUNT_LO + COUNT_W;
	localparam int M_TDATA_W     = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD     = 3'd0,
		CMD_REMOVE  = 3'd1,
		CMD_PLAY    = 3'd2,
		CMD_PAUSE   = 3'd3,
		CMD_RESTART = 3'd4
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_INVALID = 2'd2
	} status_t;

endpackage

// ----- hdl/voice_channel_allocator.sv -----
// Voice channel allocator: channel table with a free list and a doubly linked active list.
// Depends on vca_pkg (table size, field layout, command and status codes).
//
// Pipeline: input register, then result register; an item's result is captured in the result
// register when the item leaves the input register.
// Throughput: one item per cycle while the output is not stalled; the table and list heads update in
// the cycle the item leaves the input register, so each item sees every earlier item's changes.
// Reset (arst_n low): free chain rebuilt as 0..CHANNELS-1, active list empty, count zero,
// channel table cleared (flags, stream address, sample counts and position), both stages empty.
module voice_channel_allocator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// handle[3:0], stream_addr[35:4], stream_bytes[59:36], start_playing[60],
	// looping[61], zero pad[63:62]
	input  logic [vca_pkg::S_TDATA_W-1:0]  s_axis_tdata,
	// cmd[2:0]
	input  logic [vca_pkg::CMD_W-1:0]      s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// handle_out[3:0], status[5:4], used_channels[10:6], zero pad[15:11]
	output logic [vca_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
	import vca_pkg::*;

	// Input stage
	logic                 vld_s1;
	logic [CMD_W-1:0]     cmd_s1;
	logic [HANDLE_W-1:0]  handle_s1;
	logic [ADDR_W-1:0]    addr_s1;
	logic [BYTES_W-1:0]   bytes_s1;
	logic                 play_s1;
	logic                 loop_s1;

	// Result stage
	logic                 vld_s2;
	logic [HANDLE_W-1:0]  hout_s2;
	logic [STATUS_W-1:0]  status_s2;
	logic [COUNT_W-1:0]   count_s2;

	// Channel table: list links with valid bits, flags, stream descriptor
	logic [HANDLE_W-1:0]  next_link_q [CHANNELS];
	logic                 next_ok_q   [CHANNELS];
	logic [HANDLE_W-1:0]  prev_link_q [CHANNELS];
	logic                 prev_ok_q   [CHANNELS];
	logic                 active_q    [CHANNELS];
	logic                 playing_q   [CHANNELS];
	logic                 loop_flag_q [CHANNELS];
	logic [ADDR_W-1:0]    stream_addr_q [CHANNELS];
	logic [SAMP_W-1:0]    sample_total_q [CHANNELS];
	logic [SAMP_W-1:0]    sample_pos_q [CHANNELS];

	logic [HANDLE_W-1:0]  active_head_q;
	logic                 active_head_ok_q;
	logic [HANDLE_W-1:0]  free_head_q;
	logic                 free_head_ok_q;
	logic [COUNT_W-1:0]   used_q;

	// Decode of the item in the input stage
	logic                 advance;
	logic                 in_range;
	logic [IDX_W-1:0]     hi;
	logic [IDX_W-1:0]     fi;
	logic                 do_add;
	logic                 do_remove;
	logic                 do_flags;
	logic [HANDLE_W-1:0]  hout_d;
	status_t              status_d;
	logic [COUNT_W-1:0]   count_d;

	// Move an item out of the input stage whenever the result slot is free or draining
	assign advance       = vld_s1 && (!vld_s2 || m_axis_tready);
	assign s_axis_tready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	// Hold the payload while stalled
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			cmd_s1    <= s_axis_tuser;
			handle_s1 <= s_axis_tdata[IN_HANDLE_LO +: HANDLE_W];
			addr_s1   <= s_axis_tdata[IN_ADDR_LO +: ADDR_W];
			bytes_s1  <= s_axis_tdata[IN_BYTES_LO +: BYTES_W];
			play_s1   <= s_axis_tdata[IN_PLAY_BIT];
			loop_s1   <= s_axis_tdata[IN_LOOP_BIT];
		end
	end

	assign in_range = {1'b0, handle_s1} < COUNT_W'(CHANNELS);
	assign hi       = handle_s1[IDX_W-1:0];
	assign fi       = free_head_q[IDX_W-1:0];

	// Command decode and result fields
	always_comb begin
		do_add    = 1'b0;
		do_remove = 1'b0;
		do_flags  = 1'b0;
		hout_d    = handle_s1;
		status_d  = ST_OK;
		count_d   = used_q;
		unique case (cmd_s1)
			CMD_ADD: begin
				if (!free_head_ok_q || used_q >= COUNT_W'(CHANNELS)) begin
					status_d = ST_FULL;
					hout_d   = '0;
				end else begin
					do_add  = 1'b1;
					hout_d  = free_head_q;
					count_d = used_q + 1'b1;
				end
			end
			CMD_REMOVE: begin
				if (!in_range || !active_q[hi]) begin
					status_d = ST_INVALID;
				end else begin
					do_remove = 1'b1;
					if (used_q != '0) begin
						count_d = used_q - 1'b1;
					end
				end
			end
			CMD_PLAY, CMD_PAUSE, CMD_RESTART: begin
				if (!in_range) begin
					status_d = ST_INVALID;
				end else begin
					do_flags = 1'b1;
				end
			end
			default: begin
				status_d = ST_INVALID;
			end
		endcase
	end

	// List and flag updates; nonblocking writes keep reads on the old table contents
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				next_link_q[i] <= HANDLE_W'(i + 1);
				next_ok_q[i]   <= (i + 1 < CHANNELS);
				prev_link_q[i] <= '0;
				prev_ok_q[i]   <= 1'b0;
				active_q[i]    <= 1'b0;
				playing_q[i]   <= 1'b0;
				loop_flag_q[i] <= 1'b0;
			end
			active_head_q    <= '0;
			active_head_ok_q <= 1'b0;
			free_head_q      <= '0;
			free_head_ok_q   <= 1'b1;
			used_q           <= '0;
		end else if (advance) begin
			used_q <= count_d;
			if (do_add) begin
				// Pop the free head and push it at the head of the active list
				free_head_q      <= next_link_q[fi];
				free_head_ok_q   <= next_ok_q[fi];
				next_link_q[fi]  <= active_head_q;
				next_ok_q[fi]    <= active_head_ok_q;
				prev_link_q[fi]  <= '0;
				prev_ok_q[fi]    <= 1'b0;
				active_q[fi]     <= 1'b1;
				playing_q[fi]    <= play_s1;
				loop_flag_q[fi]  <= loop_s1;
				if (active_head_ok_q) begin
					prev_link_q[active_head_q[IDX_W-1:0]] <= free_head_q;
					prev_ok_q[active_head_q[IDX_W-1:0]]   <= 1'b1;
				end
				active_head_q    <= free_head_q;
				active_head_ok_q <= 1'b1;
			end
			if (do_remove) begin
				// Unlink, skipping missing neighbors, then push onto the free list
				if (prev_ok_q[hi]) begin
					next_link_q[prev_link_q[hi][IDX_W-1:0]] <= next_link_q[hi];
					next_ok_q[prev_link_q[hi][IDX_W-1:0]]   <= next_ok_q[hi];
				end else begin
					active_head_q    <= next_link_q[hi];
					active_head_ok_q <= next_ok_q[hi];
				end
				if (next_ok_q[hi]) begin
					prev_link_q[next_link_q[hi][IDX_W-1:0]] <= prev_link_q[hi];
					prev_ok_q[next_link_q[hi][IDX_W-1:0]]   <= prev_ok_q[hi];
				end
				prev_link_q[hi] <= '0;
				prev_ok_q[hi]   <= 1'b0;
				next_link_q[hi] <= free_head_q;
				next_ok_q[hi]   <= free_head_ok_q;
				free_head_q     <= handle_s1;
				free_head_ok_q  <= 1'b1;
				active_q[hi]    <= 1'b0;
			end
			if (do_flags) begin
				playing_q[hi] <= (cmd_s1 == CMD_PLAY);
			end
		end
	end

	// Stream descriptor for the mixer: address, sample count, play position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				stream_addr_q[i]  <= '0;
				sample_total_q[i] <= '0;
				sample_pos_q[i]   <= '0;
			end
		end else begin
			if (advance && do_add) begin
				stream_addr_q[fi]  <= addr_s1;
				sample_total_q[fi] <= bytes_s1[BYTES_W-1:2];
				sample_pos_q[fi]   <= '0;
			end
			if (advance && do_flags && cmd_s1 == CMD_RESTART) begin
				sample_pos_q[hi] <= '0;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (advance) begin
			vld_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			hout_s2   <= hout_d;
			status_s2 <= status_d;
			count_s2  <= count_d;
		end
	end

	assign m_axis_tvalid = vld_s2;
	always_comb begin
		m_axis_tdata = '0;
		m_axis_tdata[OUT_HANDLE_LO +: HANDLE_W] = hout_s2;
		m_axis_tdata[OUT_STATUS_LO +: STATUS_W] = status_s2;
		m_axis_tdata[OUT_COUNT_LO +: COUNT_W]   = count_s2;
	end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for voice_channel_allocator: free list and active list bookkeeping.
// Depends on vca_pkg for field layout, table size, command and status codes.
module tb_top;
	import vca_pkg::*;

	// Expected fields of one result item
	typedef struct packed {
		logic [HANDLE_W-1:0] handle_out;
		status_t             status;
		logic [COUNT_W-1:0]  used;
	} alloc_result_t;

	localparam int TABLE_SLOTS = 16;
	localparam int MAX_REPORTS = 10;

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	// handle, stream_addr, stream_bytes, start_playing, looping, zero pad (low bit up)
	logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
	// cmd
	logic [CMD_W-1:0]     s_axis_tuser  = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	// handle_out, status, used_channels, zero pad (low bit up)
	logic [M_TDATA_W-1:0] m_axis_tdata;

	// Shadow copy of the channel table and list heads
	logic [HANDLE_W-1:0] link_next [TABLE_SLOTS];
	bit                  link_next_ok [TABLE_SLOTS];
	logic [HANDLE_W-1:0] link_prev [TABLE_SLOTS];
	bit                  link_prev_ok [TABLE_SLOTS];
	logic [ADDR_W-1:0]   chan_addr [TABLE_SLOTS];
	logic [SAMP_W-1:0]   chan_samples [TABLE_SLOTS];
	logic [SAMP_W-1:0]   chan_pos [TABLE_SLOTS];
	bit                  chan_loop [TABLE_SLOTS];
	bit                  chan_playing [TABLE_SLOTS];
	bit                  chan_live [TABLE_SLOTS];
	logic [HANDLE_W-1:0] live_head;
	bit                  live_head_ok;
	logic [HANDLE_W-1:0] spare_head;
	bit                  spare_head_ok;
	logic [COUNT_W-1:0]  live_count;

	alloc_result_t pending_results [$];
	int            mismatch_count = 0;
	bit            src_gaps_on    = 1'b1;
	bit            sink_stalls_on = 1'b1;
	int            sink_hold      = 0;

	voice_channel_allocator DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Hard stop in case the block hangs or a handshake never completes
	initial begin
		#1000000;
		$display("status: fail");
		$finish;
	end

	// Rebuild the shadow table as it stands after reset: free chain 0..CHANNELS-1
	task automatic clear_shadow();
		for (int i = 0; i < TABLE_SLOTS; i++) begin
			link_next[i]    = '0;
			link_next_ok[i] = (i + 1 < CHANNELS);
			if (i + 1 < CHANNELS)
				link_next[i] = HANDLE_W'(i + 1);
			link_prev[i]    = '0;
			link_prev_ok[i] = 1'b0;
			chan_addr[i]    = '0;
			chan_samples[i] = '0;
			chan_pos[i]     = '0;
			chan_loop[i]    = 1'b0;
			chan_playing[i] = 1'b0;
			chan_live[i]    = 1'b0;
		end
		live_head     = '0;
		live_head_ok  = 1'b0;
		spare_head    = '0;
		spare_head_ok = 1'b1;
		live_count    = '0;
	endtask

	// Apply one command to the shadow table and return the result it causes
	function automatic alloc_result_t apply_command(input logic [CMD_W-1:0] cmd,
			input logic [HANDLE_W-1:0] handle, input logic [ADDR_W-1:0] addr,
			input logic [BYTES_W-1:0] bytes, input bit play, input bit loop);
		alloc_result_t       res;
		logic [HANDLE_W-1:0] slot;
		logic [HANDLE_W-1:0] nb_next;
		logic [HANDLE_W-1:0] nb_prev;
		bit                  nb_next_ok;
		bit                  nb_prev_ok;
		bit                  in_range;

		res.handle_out = handle;
		res.status     = ST_OK;
		in_range       = (handle < CHANNELS);
		if (cmd == CMD_ADD) begin
			if (!spare_head_ok || live_count >= CHANNELS) begin
				res.status     = ST_FULL;
				res.handle_out = '0;
			end else begin
				slot          = spare_head;
				spare_head    = link_next[slot];
				spare_head_ok = link_next_ok[slot];
				chan_addr[slot]    = addr;
				chan_samples[slot] = SAMP_W'(bytes >> 2);
				chan_pos[slot]     = '0;
				chan_loop[slot]    = loop;
				chan_playing[slot] = play;
				chan_live[slot]    = 1'b1;
				// Link in at the head of the active list
				link_next[slot]    = live_head;
				link_next_ok[slot] = live_head_ok;
				link_prev[slot]    = '0;
				link_prev_ok[slot] = 1'b0;
				if (live_head_ok) begin
					link_prev[live_head]    = slot;
					link_prev_ok[live_head] = 1'b1;
				end
				live_head      = slot;
				live_head_ok   = 1'b1;
				live_count     = live_count + 1'b1;
				res.handle_out = slot;
			end
		end else if (cmd == CMD_REMOVE) begin
			if (!in_range || !chan_live[handle]) begin
				res.status = ST_INVALID;
			end else begin
				nb_next    = link_next[handle];
				nb_next_ok = link_next_ok[handle];
				nb_prev    = link_prev[handle];
				nb_prev_ok = link_prev_ok[handle];
				// Skip missing neighbors; a removed head hands the head to its successor
				if (nb_prev_ok) begin
					link_next[nb_prev]    = nb_next;
					link_next_ok[nb_prev] = nb_next_ok;
				end else begin
					live_head    = nb_next;
					live_head_ok = nb_next_ok;
				end
				if (nb_next_ok) begin
					link_prev[nb_next]    = nb_prev;
					link_prev_ok[nb_next] = nb_prev_ok;
				end
				link_prev[handle]    = '0;
				link_prev_ok[handle] = 1'b0;
				link_next[handle]    = spare_head;
				link_next_ok[handle] = spare_head_ok;
				spare_head           = handle;
				spare_head_ok        = 1'b1;
				chan_live[handle]    = 1'b0;
				if (live_count > 0)
					live_count = live_count - 1'b1;
			end
		end else if (cmd == CMD_PLAY || cmd == CMD_PAUSE || cmd == CMD_RESTART) begin
			// Flags change even on an inactive channel
			if (!in_range) begin
				res.status = ST_INVALID;
			end else if (cmd == CMD_PLAY) begin
				chan_playing[handle] = 1'b1;
			end else begin
				chan_playing[handle] = 1'b0;
				if (cmd == CMD_RESTART)
					chan_pos[handle] = '0;
			end
		end else begin
			res.status = ST_INVALID;
		end
		res.used = live_count;
		return res;
	endfunction

	// Hand one item to the block; predict its result once it is taken
	task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [HANDLE_W-1:0] handle,
			input logic [ADDR_W-1:0] addr, input logic [BYTES_W-1:0] bytes,
			input bit play, input bit loop);
		logic [S_TDATA_W-1:0] word;

		// Drop valid for a random burst now and then
		if (src_gaps_on && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		word = '0;
		word[IN_HANDLE_LO +: HANDLE_W] = handle;
		word[IN_ADDR_LO +: ADDR_W]     = addr;
		word[IN_BYTES_LO +: BYTES_W]   = bytes;
		word[IN_PLAY_BIT]              = play;
		word[IN_LOOP_BIT]              = loop;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= word;
		s_axis_tuser  <= cmd;
		// Hold the item until the block takes it
		do
			@(posedge clk);
		while (!s_axis_tready);
		pending_results.push_back(apply_command(cmd, handle, addr, bytes, play, loop));
	endtask

	// Hold off the sender until every predicted result has come back
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0);
	endtask

	// Pick a channel that is live in the shadow table, or any in-range one if none is
	function automatic logic [HANDLE_W-1:0] pick_live();
		logic [HANDLE_W-1:0] live [$];

		for (int i = 0; i < CHANNELS; i++)
			if (chan_live[i])
				live.push_back(HANDLE_W'(i));
		if (live.size() == 0)
			return HANDLE_W'($urandom_range(0, CHANNELS - 1));
		return live[$urandom_range(0, live.size() - 1)];
	endfunction

	// Fill every channel with extreme and random streams, then overflow the table
	task automatic test_fill_table();
		send_item(CMD_ADD, '0, '0, '0, 1'b0, 1'b0);
		send_item(CMD_ADD, '1, '1, '1, 1'b1, 1'b1);
		send_item(CMD_ADD, 4'd5, 32'h8000_0000, 24'd3, 1'b1, 1'b0);
		send_item(CMD_ADD, 4'd10, 32'h0000_0001, 24'd4, 1'b0, 1'b1);
		for (int i = 4; i < CHANNELS; i++)
			send_item(CMD_ADD, HANDLE_W'($urandom), $urandom, BYTES_W'($urandom),
				1'($urandom), 1'($urandom));
		// Empty free list: reports full with a zero handle
		send_item(CMD_ADD, 4'd9, $urandom, BYTES_W'($urandom), 1'b1, 1'b1);
	endtask

	// Play, pause and restart on live channels and on handles past the table
	task automatic test_flag_updates();
		send_item(CMD_PLAY, 4'd2, '0, '0, 1'b0, 1'b0);
		send_item(CMD_PAUSE, 4'd2, '0, '0, 1'b0, 1'b0);
		send_item(CMD_RESTART, 4'd5, '0, '0, 1'b0, 1'b0);
		send_item(CMD_PLAY, 4'd15, '0, '0, 1'b0, 1'b0);
		send_item(CMD_RESTART, HANDLE_W'(CHANNELS), '0, '0, 1'b0, 1'b0);
	endtask

	// Unlink the head, the tail and a middle channel, then poke a freed one
	task automatic test_list_unlink();
		send_item(CMD_REMOVE, HANDLE_W'(CHANNELS - 1), '0, '0, 1'b0, 1'b0);
		send_item(CMD_REMOVE, 4'd0, '0, '0, 1'b0, 1'b0);
		send_item(CMD_REMOVE, 4'd4, '0, '0, 1'b0, 1'b0);
		send_item(CMD_REMOVE, 4'd4, '0, '0, 1'b0, 1'b0);
		send_item(CMD_REMOVE, 4'd15, '0, '0, 1'b0, 1'b0);
		// Inactive channel still takes the flag change
		send_item(CMD_PAUSE, 4'd4, '0, '0, 1'b0, 1'b0);
		send_item(CMD_ADD, 4'd0, 32'hDEAD_BEEF, 24'd100, 1'b1, 1'b0);
	endtask

	// Codes above restart change nothing
	task automatic test_unknown_commands();
		for (int c = CMD_RESTART + 1; c < (1 << CMD_W); c++)
			send_item(CMD_W'(c), HANDLE_W'($urandom), $urandom, BYTES_W'($urandom),
				1'($urandom), 1'($urandom));
	endtask

	// Mostly well-formed traffic in add-heavy and remove-heavy stretches, plus noise
	task automatic test_random_traffic(input int count);
		int                  roll;
		int                  add_pct;
		logic [CMD_W-1:0]    cmd;
		logic [HANDLE_W-1:0] handle;

		add_pct = 60;
		for (int n = 0; n < count; n++) begin
			// Swing the fill level between empty and full
			if (n % 40 == 0)
				add_pct = (add_pct == 60) ? 25 : 60;
			roll   = $urandom_range(0, 99);
			handle = HANDLE_W'($urandom);
			if (roll < add_pct) begin
				cmd = CMD_ADD;
			end else if (roll < 72) begin
				cmd    = CMD_REMOVE;
				handle = pick_live();
			end else if (roll < 90) begin
				cmd    = CMD_W'($urandom_range(CMD_PLAY, CMD_RESTART));
				handle = $urandom_range(0, 1) ? pick_live()
					: HANDLE_W'($urandom_range(0, CHANNELS - 1));
			end else if (roll < 95) begin
				cmd = CMD_W'($urandom_range(CMD_ADD, CMD_RESTART));
			end else begin
				cmd = CMD_W'($urandom_range(CMD_RESTART + 1, (1 << CMD_W) - 1));
			end
			send_item(cmd, handle, $urandom, BYTES_W'($urandom), 1'($urandom), 1'($urandom));
		end
	endtask

	// Receiver: drop ready for random bursts while stalls are enabled
	always @(posedge clk) begin
		if (sink_hold > 0) begin
			sink_hold--;
		end else if (sink_stalls_on && $urandom_range(0, 7) == 0) begin
			m_axis_tready <= 1'b0;
			sink_hold = $urandom_range(0, 11);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	task automatic note_mismatch(input string what, input int want, input int got);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("mismatch: %s expected %0d actual %0d", what, want, got);
	endtask

	// Compare each result item with the oldest prediction
	always @(posedge clk) begin
		alloc_result_t want;

		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				note_mismatch("unexpected result, tdata", 0, int'(m_axis_tdata));
			end else begin
				want = pending_results.pop_front();
				if (m_axis_tdata[OUT_HANDLE_LO +: HANDLE_W] !== want.handle_out)
					note_mismatch("handle_out", want.handle_out,
						m_axis_tdata[OUT_HANDLE_LO +: HANDLE_W]);
				if (m_axis_tdata[OUT_STATUS_LO +: STATUS_W] !== want.status)
					note_mismatch("status", want.status,
						m_axis_tdata[OUT_STATUS_LO +: STATUS_W]);
				if (m_axis_tdata[OUT_COUNT_LO +: COUNT_W] !== want.used)
					note_mismatch("used_channels", want.used,
						m_axis_tdata[OUT_COUNT_LO +: COUNT_W]);
			end
		end
	end

	initial begin
		clear_shadow();
		// Hold reset, then release on an edge
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_fill_table();
		test_flag_updates();
		test_list_unlink();
		test_unknown_commands();
		wait_drained();

		test_random_traffic(750);
		// Closing stretch at full rate on both sides
		src_gaps_on    = 1'b0;
		sink_stalls_on = 1'b0;
		test_random_traffic(150);
		s_axis_tvalid <= 1'b0;

		// Wait for the last results, then keep the clock running to catch strays
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
